// ===== design/obbfc_pkg.sv =====
// Shared types and constants for the oriented-box frustum classifier.
// No dependencies; imported by every module of the block.
package obbfc_pkg;

	// Plane register file
	localparam int NUM_REGS   = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int PLANE_W    = 64;
	localparam int COEF_W     = 16;

	// Q1.14 normal times Q16.8 coordinate leaves 22 fraction bits
	localparam int FRAC_SHIFT = 22;

	typedef enum logic [1:0] {
		POS_BACK  = 2'd0,
		POS_FRONT = 2'd1,
		POS_SPAN  = 2'd2
	} position_t;

	// Per-plane verdict leaving a lane
	typedef struct packed {
		logic valid;
		logic cull;   // center distance at or below minus radius
		logic span;   // center distance at or below radius
		logic back;   // distance plus one unit below minus radius
	} plane_flags_t;

endpackage

// ===== design/obbfc_planes.sv =====
// Plane coefficient register file, written over the configuration channel.
// Depends on obbfc_pkg.
module obbfc_planes
	import obbfc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PLANE_W-1:0]   cfg_data,
	output logic [PLANE_W-1:0]   planes [NUM_REGS]
);

	logic [PLANE_W-1:0] planes_q [NUM_REGS];

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				planes_q[i] <= '0;
			end
		end else if (cfg_valid && cfg_ready && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
			planes_q[cfg_index] <= cfg_data;
		end
	end

	assign planes = planes_q;

endmodule

// ===== design/obbfc_lane.sv =====
// Four-stage test of one box against one plane: products, dot products,
// radius and center distance, then the three comparisons. Depends on obbfc_pkg.
module obbfc_lane
	import obbfc_pkg::*;
#(
	parameter int COORD_BITS = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic signed [COORD_BITS-1:0] coord [12],  // center, u, v, w; x,y,z each
	input  logic [PLANE_W-1:0]           plane,
	output plane_flags_t                 flags
);

	localparam int PROD_W = COORD_BITS + COEF_W;
	localparam int DOT_W  = PROD_W + 2;
	localparam int ACC_W  = COORD_BITS + 24;
	localparam int DSH_W  = COEF_W + FRAC_SHIFT;

	logic signed [COEF_W-1:0] normal [3];
	logic signed [COEF_W-1:0] offset_d;

	logic                     valid_s1, valid_s2, valid_s3;
	logic signed [PROD_W-1:0] prod_s1 [12];
	logic signed [DOT_W-1:0]  dot_s2 [4];
	logic signed [ACC_W-1:0]  r_s3, s_s3;
	plane_flags_t             flags_s4;

	logic signed [ACC_W-1:0] dot_ext [4];
	logic signed [ACC_W-1:0] dot_abs [3];
	logic signed [ACC_W-1:0] d_scaled;
	logic signed [ACC_W-1:0] one_unit;
	logic signed [ACC_W-1:0] neg_r;

	assign normal[0] = plane[15:0];
	assign normal[1] = plane[31:16];
	assign normal[2] = plane[47:32];
	assign offset_d  = plane[63:48];

	// Stage 1: twelve products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 12; k++) begin
			prod_s1[k] <= PROD_W'(normal[k % 3] * coord[k]);
		end
	end

	// Stage 2: dot products with center and the three half-axes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < 4; j++) begin
			dot_s2[j] <= DOT_W'(prod_s1[3*j]) + DOT_W'(prod_s1[3*j+1])
				+ DOT_W'(prod_s1[3*j+2]);
		end
	end

	// Stage 3: projected radius and signed center distance
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			dot_ext[j] = ACC_W'(dot_s2[j]);
		end
		for (int j = 0; j < 3; j++) begin
			dot_abs[j] = dot_ext[j+1][ACC_W-1] ? -dot_ext[j+1] : dot_ext[j+1];
		end
	end

	assign d_scaled = $signed({{(ACC_W-DSH_W){offset_d[COEF_W-1]}}, offset_d,
		{FRAC_SHIFT{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		r_s3 <= dot_abs[0] + dot_abs[1] + dot_abs[2];
		s_s3 <= dot_ext[0] + d_scaled;
	end

	// Stage 4: comparisons
	assign one_unit = $signed({{(ACC_W-FRAC_SHIFT-1){1'b0}}, 1'b1, {FRAC_SHIFT{1'b0}}});
	assign neg_r    = -r_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s4 <= '0;
		end else begin
			flags_s4.valid <= valid_s3;
			flags_s4.cull  <= (s_s3 <= neg_r);
			flags_s4.span  <= (s_s3 <= r_s3);
			flags_s4.back  <= ((s_s3 + one_unit) < neg_r);
		end
	end

	assign flags = flags_s4;

endmodule

// ===== design/obb_frustum_classify.sv =====
// Top level of the oriented-box frustum classifier: plane registers, one
// pipeline lane per plane and the result merge. Depends on obbfc_pkg,
// obbfc_planes and obbfc_lane.
//
// Usage:
//  - Input: drive the box center and the three extent-scaled half-axes and
//    raise start for one cycle; the transaction is taken on any edge where
//    start is high and busy is low. busy is always low: a new box may be
//    issued every cycle.
//  - Output: done pulses for one cycle with visible and position valid in
//    that cycle. There is no back-pressure; the receiver must take it.
//  - Pipeline: an accepted box passes through the registered stages products,
//    dot products, radius/distance, compares and merge before done.
//    Throughput: one box per cycle, set by the fully pipelined lanes.
//  - Configuration: six 64-bit plane registers on cfg_valid/cfg_ready with
//    cfg_index and cfg_data; cfg_ready is always high, out-of-range indexes
//    are dropped. Write only while no box is in flight.
//  - Reset: arst_n clears all planes to zero and empties the pipeline; with
//    zero planes every box comes out not visible and spanning.
module obb_frustum_classify
	import obbfc_pkg::*;
#(
	parameter int PLANE_COUNT = 6,
	parameter int COORD_BITS  = 24
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// item channel
	input  logic                         start,
	output logic                         busy,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  logic signed [COORD_BITS-1:0] center_z,
	input  logic signed [COORD_BITS-1:0] axis_u_x,
	input  logic signed [COORD_BITS-1:0] axis_u_y,
	input  logic signed [COORD_BITS-1:0] axis_u_z,
	input  logic signed [COORD_BITS-1:0] axis_v_x,
	input  logic signed [COORD_BITS-1:0] axis_v_y,
	input  logic signed [COORD_BITS-1:0] axis_v_z,
	input  logic signed [COORD_BITS-1:0] axis_w_x,
	input  logic signed [COORD_BITS-1:0] axis_w_y,
	input  logic signed [COORD_BITS-1:0] axis_w_z,
	// result channel
	output logic                         done,
	output logic                         visible,
	output logic [1:0]                   position,
	// configuration channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [PLANE_W-1:0]           cfg_data
);

	logic [PLANE_W-1:0]           planes [NUM_REGS];
	logic signed [COORD_BITS-1:0] coord [12];
	plane_flags_t                 lane_flags [PLANE_COUNT];

	logic      any_cull, any_span, any_back;
	logic      done_s5, visible_s5;
	position_t position_s5;

	// Pipeline never holds off: a box enters on every start
	assign busy = 1'b0;

	assign coord[0]  = center_x;
	assign coord[1]  = center_y;
	assign coord[2]  = center_z;
	assign coord[3]  = axis_u_x;
	assign coord[4]  = axis_u_y;
	assign coord[5]  = axis_u_z;
	assign coord[6]  = axis_v_x;
	assign coord[7]  = axis_v_y;
	assign coord[8]  = axis_v_z;
	assign coord[9]  = axis_w_x;
	assign coord[10] = axis_w_y;
	assign coord[11] = axis_w_z;

	obbfc_planes u_planes (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.planes    (planes)
	);

	// One lane per active plane; registers beyond PLANE_COUNT are stored only
	for (genvar p = 0; p < PLANE_COUNT; p++) begin : g_lane
		obbfc_lane #(
			.COORD_BITS (COORD_BITS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (start && !busy),
			.coord    (coord),
			.plane    (planes[p]),
			.flags    (lane_flags[p])
		);
	end

	// Merge across planes. All lanes run in lockstep, so lane 0 carries valid.
	always_comb begin
		any_cull = 1'b0;
		any_span = 1'b0;
		any_back = 1'b0;
		for (int p = 0; p < PLANE_COUNT; p++) begin
			any_cull = any_cull | lane_flags[p].cull;
			any_span = any_span | lane_flags[p].span;
			any_back = any_back | lane_flags[p].back;
		end
	end

	// Stage 5: result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s5     <= 1'b0;
			visible_s5  <= 1'b0;
			position_s5 <= POS_BACK;
		end else begin
			done_s5    <= lane_flags[0].valid;
			visible_s5 <= !any_cull;
			if (any_back) begin
				position_s5 <= POS_BACK;
			end else if (any_span) begin
				position_s5 <= POS_SPAN;
			end else begin
				position_s5 <= POS_FRONT;
			end
		end
	end

	assign done     = done_s5;
	assign visible  = visible_s5;
	assign position = position_s5;

	// Every accepted box is followed by a result strobe from the result register
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##5 done)
		else $error("result strobe missing after accepted box");

	// A culled box can never be classified as fully in front
	a_cull_not_front: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !visible) |-> (position != POS_FRONT))
		else $error("invisible box reported in front");

	// Back of a plane implies culled by that plane
	a_back_culled: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (position == POS_BACK)) |-> !visible)
		else $error("box behind a plane reported visible");

endmodule
